### rtl/gcl_pkg.sv
`timescale 1ns / 1ps

package gcl_pkg;

    // field widths of the channels
    localparam int KIND_W  = 2;
    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int LABEL_W = 10;
    localparam int TOTAL_W = 11;

    // command codes carried in kind
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_ADD   = 2'd0;
    localparam kind_t KIND_QUERY = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    // node count after reset
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

endpackage

### rtl/gcl_ram.sv
`timescale 1ns / 1ps

module gcl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/graph_component_labeler.sv
`timescale 1ns / 1ps

// channel   ports                                   direction
// --------  --------------------------------------  ---------
// s_        s_kind, s_node_a, s_node_b              in
// m_        m_component_label, m_component_total,   out
//           m_out_of_range
// cfg_      cfg_data (node_count)                   in
//
// add edge: walks the parent chains of both endpoints, one parent hop at a time
// query with current labels: reads the label of node a; stale labels add a relabel pass
// over every node in use (parent read, then label read of the parent if not a root)
// clear: one parent entry written per cycle over all NODES entries; the same pass runs after
// reset and no item is taken during it
// a finished query waits in its state while the output register is still full

module graph_component_labeler #(
    parameter int NODES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gcl_pkg::KIND_W-1:0]  s_kind,
    input  logic [gcl_pkg::NODE_W-1:0]  s_node_a,
    input  logic [gcl_pkg::NODE_W-1:0]  s_node_b,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gcl_pkg::LABEL_W-1:0] m_component_label,
    output logic [gcl_pkg::TOTAL_W-1:0] m_component_total,
    output logic                        m_out_of_range,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gcl_pkg::COUNT_W-1:0] cfg_data
);

    localparam int IW  = $clog2(NODES);
    localparam int NW1 = $clog2(NODES + 1);
    localparam int CW  = (NW1 > gcl_pkg::COUNT_W) ? NW1 : gcl_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_RL_ISSUE,
        ST_RL_PAR,
        ST_RL_LAB,
        ST_Q_ISSUE,
        ST_Q_DATA
    } state_t;

    state_t state_reg, state_next;

    logic [gcl_pkg::COUNT_W-1:0] node_count_reg, node_count_next;
    logic                        labels_current_reg, labels_current_next;
    logic [NW1-1:0]              tally_reg, tally_next;
    logic [NW1-1:0]              idx_reg, idx_next;
    logic [IW-1:0]               cur_reg, cur_next;
    logic [IW-1:0]               ra_reg, ra_next;
    logic [IW-1:0]               a_idx_reg, a_idx_next;
    logic [IW-1:0]               b_idx_reg, b_idx_next;
    logic                        a_oor_reg, a_oor_next;

    logic                        m_valid_reg, m_valid_next;
    logic [gcl_pkg::LABEL_W-1:0] m_label_reg, m_label_next;
    logic [gcl_pkg::TOTAL_W-1:0] m_total_reg, m_total_next;
    logic                        m_oor_reg, m_oor_next;

    logic          p_we, p_re, l_we, l_re;
    logic [IW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [IW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;

    logic [CW-1:0] count_ext, n_eff;
    logic          a_in, b_in;
    logic [IW-1:0] s_a_idx, s_b_idx;

    gcl_ram #(.DEPTH(NODES), .WIDTH(IW)) u_parent (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    gcl_ram #(.DEPTH(NODES), .WIDTH(IW)) u_label (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // nodes in use, clamped to 1..NODES
    always_comb begin
        count_ext = CW'(node_count_reg);
        if (count_ext == '0) begin
            n_eff = CW'(1);
        end else if (count_ext > CW'(NODES)) begin
            n_eff = CW'(NODES);
        end else begin
            n_eff = count_ext;
        end
    end

    assign a_in    = CW'(s_node_a) < n_eff;
    assign b_in    = CW'(s_node_b) < n_eff;
    assign s_a_idx = IW'(s_node_a);
    assign s_b_idx = IW'(s_node_b);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next          = state_reg;
        node_count_next     = node_count_reg;
        labels_current_next = labels_current_reg;
        tally_next          = tally_reg;
        idx_next            = idx_reg;
        cur_next            = cur_reg;
        ra_next             = ra_reg;
        a_idx_next          = a_idx_reg;
        b_idx_next          = b_idx_reg;
        a_oor_next          = a_oor_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_label_next        = m_label_reg;
        m_total_next        = m_total_reg;
        m_oor_next          = m_oor_reg;

        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_re    = 1'b0;
        p_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_re    = 1'b0;
        l_raddr = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = IW'(idx_reg);
                p_wdata = IW'(idx_reg);
                if (idx_reg == NW1'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + NW1'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    a_idx_next = s_a_idx;
                    b_idx_next = s_b_idx;
                    a_oor_next = !a_in;
                    case (s_kind)
                        gcl_pkg::KIND_ADD: begin
                            // edges touching nodes out of use are dropped
                            if (a_in && b_in) begin
                                p_re       = 1'b1;
                                p_raddr    = s_a_idx;
                                cur_next   = s_a_idx;
                                state_next = ST_FIND_A;
                            end
                        end
                        gcl_pkg::KIND_QUERY: begin
                            if (labels_current_reg) begin
                                state_next = ST_Q_ISSUE;
                            end else begin
                                idx_next   = '0;
                                tally_next = '0;
                                state_next = ST_RL_ISSUE;
                            end
                        end
                        gcl_pkg::KIND_CLEAR: begin
                            idx_next            = '0;
                            tally_next          = '0;
                            labels_current_next = 1'b0;
                            state_next          = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIND_A: begin
                p_re = 1'b1;
                if (p_rdata == cur_reg) begin
                    // root of a found: point a straight at it, start walk of b
                    ra_next    = cur_reg;
                    p_we       = 1'b1;
                    p_waddr    = a_idx_reg;
                    p_wdata    = cur_reg;
                    p_raddr    = b_idx_reg;
                    cur_next   = b_idx_reg;
                    state_next = ST_FIND_B;
                end else begin
                    p_raddr  = p_rdata;
                    cur_next = p_rdata;
                end
            end
            ST_FIND_B: begin
                if (p_rdata == cur_reg) begin
                    if (ra_reg != cur_reg) begin
                        // larger root hangs under the smaller one
                        p_we                = 1'b1;
                        p_waddr             = (ra_reg < cur_reg) ? cur_reg : ra_reg;
                        p_wdata             = (ra_reg < cur_reg) ? ra_reg : cur_reg;
                        labels_current_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end else begin
                    p_re     = 1'b1;
                    p_raddr  = p_rdata;
                    cur_next = p_rdata;
                end
            end
            ST_RL_ISSUE: begin
                if (CW'(idx_reg) < n_eff) begin
                    p_re       = 1'b1;
                    p_raddr    = IW'(idx_reg);
                    state_next = ST_RL_PAR;
                end else begin
                    labels_current_next = 1'b1;
                    state_next          = ST_Q_ISSUE;
                end
            end
            ST_RL_PAR: begin
                // parents sit below their child, so the parent is labeled already
                if (p_rdata == IW'(idx_reg)) begin
                    l_we       = 1'b1;
                    l_waddr    = IW'(idx_reg);
                    l_wdata    = IW'(tally_reg);
                    tally_next = tally_reg + NW1'(1);
                    idx_next   = idx_reg + NW1'(1);
                    state_next = ST_RL_ISSUE;
                end else begin
                    l_re       = 1'b1;
                    l_raddr    = p_rdata;
                    state_next = ST_RL_LAB;
                end
            end
            ST_RL_LAB: begin
                l_we       = 1'b1;
                l_waddr    = IW'(idx_reg);
                l_wdata    = l_rdata;
                idx_next   = idx_reg + NW1'(1);
                state_next = ST_RL_ISSUE;
            end
            ST_Q_ISSUE: begin
                if (!a_oor_reg) begin
                    l_re    = 1'b1;
                    l_raddr = a_idx_reg;
                end
                state_next = ST_Q_DATA;
            end
            ST_Q_DATA: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_label_next = a_oor_reg ? '0 : gcl_pkg::LABEL_W'(l_rdata);
                    m_total_next = gcl_pkg::TOTAL_W'(tally_reg);
                    m_oor_next   = a_oor_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            node_count_next     = cfg_data;
            labels_current_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            node_count_reg     <= gcl_pkg::NODE_COUNT_RESET;
            labels_current_reg <= 1'b0;
            tally_reg          <= '0;
            idx_reg            <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            node_count_reg     <= node_count_next;
            labels_current_reg <= labels_current_next;
            tally_reg          <= tally_next;
            idx_reg            <= idx_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        ra_reg      <= ra_next;
        a_idx_reg   <= a_idx_next;
        b_idx_reg   <= b_idx_next;
        a_oor_reg   <= a_oor_next;
        m_label_reg <= m_label_next;
        m_total_reg <= m_total_next;
        m_oor_reg   <= m_oor_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_component_label = m_label_reg;
    assign m_component_total = m_total_reg;
    assign m_out_of_range    = m_oor_reg;

endmodule

### dv/tb_graph_component_labeler.sv
`timescale 1ns / 1ps

module tb_graph_component_labeler;

    localparam int NODES         = 1024;
    localparam int SETTLE_CYCLES = 2200;     // covers the longest add walk and a clear
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int REPORT_MAX    = 10;

    localparam gcl_pkg::kind_t KIND_UNUSED = 2'd3;

    typedef struct packed {
        gcl_pkg::kind_t                kind;
        logic [gcl_pkg::NODE_W-1:0]    node_a;
        logic [gcl_pkg::NODE_W-1:0]    node_b;
    } command_t;

    typedef struct packed {
        logic [gcl_pkg::LABEL_W-1:0]   label;
        logic [gcl_pkg::TOTAL_W-1:0]   total;
        logic                          out_of_range;
    } labeling_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [gcl_pkg::KIND_W-1:0]    s_kind = '0;
    logic [gcl_pkg::NODE_W-1:0]    s_node_a = '0;
    logic [gcl_pkg::NODE_W-1:0]    s_node_b = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [gcl_pkg::LABEL_W-1:0]   m_component_label;
    logic [gcl_pkg::TOTAL_W-1:0]   m_component_total;
    logic                          m_out_of_range;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [gcl_pkg::COUNT_W-1:0]   cfg_data = '0;

    // graph mirror
    logic [gcl_pkg::NODE_W-1:0]    parent_of [NODES];
    logic [gcl_pkg::LABEL_W-1:0]   label_of [NODES];
    bit                            labels_fresh;
    int unsigned                   tally;
    logic [gcl_pkg::COUNT_W-1:0]   node_count_reg;

    command_t            pending_cmds [$];
    labeling_t           labelings_due [$];

    int unsigned         sender_idle_pct = 0;
    int unsigned         stall_pct = 0;
    int unsigned         items_queued = 0;
    int unsigned         items_accepted = 0;
    int unsigned         results_seen = 0;
    int unsigned         node_count_writes = 0;
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;

    graph_component_labeler #(
        .NODES(NODES)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_node_a          (s_node_a),
        .s_node_b          (s_node_b),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_component_label (m_component_label),
        .m_component_total (m_component_total),
        .m_out_of_range    (m_out_of_range),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int unsigned nodes_in_use(logic [gcl_pkg::COUNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > NODES) return NODES;
        return cnt;
    endfunction

    function automatic int unsigned find_root(int unsigned x);
        int unsigned top;
        int unsigned hop;
        top = x;
        while (parent_of[top] != top) top = parent_of[top];
        // flatten the path on the way
        while (parent_of[x] != top) begin
            hop = parent_of[x];
            parent_of[x] = top[gcl_pkg::NODE_W-1:0];
            x = hop;
        end
        return top;
    endfunction

    function automatic void reset_graph();
        for (int unsigned i = 0; i < NODES; i++) parent_of[i] = i[gcl_pkg::NODE_W-1:0];
        labels_fresh = 1'b0;
        tally = 0;
    endfunction

    // roots numbered in ascending order of their smallest member
    function automatic void relabel_graph();
        int unsigned n;
        int unsigned r;
        n = nodes_in_use(node_count_reg);
        tally = 0;
        for (int unsigned i = 0; i < n; i++) begin
            r = find_root(i);
            if (r == i) begin
                label_of[i] = tally[gcl_pkg::LABEL_W-1:0];
                tally++;
            end else begin
                label_of[i] = label_of[r];
            end
        end
        labels_fresh = 1'b1;
    endfunction

    function automatic void apply_command(command_t c);
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        labeling_t   ans;
        n = nodes_in_use(node_count_reg);
        case (c.kind)
            gcl_pkg::KIND_ADD: begin
                // edges touching unused nodes are dropped
                if (c.node_a < n && c.node_b < n) begin
                    ra = find_root(c.node_a);
                    rb = find_root(c.node_b);
                    if (ra != rb) begin
                        if (ra < rb) parent_of[rb] = ra[gcl_pkg::NODE_W-1:0];
                        else parent_of[ra] = rb[gcl_pkg::NODE_W-1:0];
                        labels_fresh = 1'b0;
                    end
                end
            end
            gcl_pkg::KIND_CLEAR: begin
                reset_graph();
            end
            gcl_pkg::KIND_QUERY: begin
                if (!labels_fresh) relabel_graph();
                if (c.node_a < n) begin
                    ans.label = label_of[c.node_a];
                    ans.out_of_range = 1'b0;
                end else begin
                    ans.label = '0;
                    ans.out_of_range = 1'b1;
                end
                ans.total = tally[gcl_pkg::TOTAL_W-1:0];
                labelings_due.insert(labelings_due.size(), ans);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_item(gcl_pkg::kind_t k, int unsigned a, int unsigned b);
        command_t c;
        c.kind = k;
        c.node_a = a[gcl_pkg::NODE_W-1:0];
        c.node_b = b[gcl_pkg::NODE_W-1:0];
        pending_cmds.insert(pending_cmds.size(), c);
        items_queued++;
    endfunction

    function automatic void note_failure(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    always @(posedge aclk) begin : drive_proc
        command_t taken;
        command_t next_cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken.kind = s_kind;
                taken.node_a = s_node_a;
                taken.node_b = s_node_b;
                apply_command(taken);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    s_valid  <= 1'b1;
                    s_kind   <= next_cmd.kind;
                    s_node_a <= next_cmd.node_a;
                    s_node_b <= next_cmd.node_b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_proc
        labeling_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (labelings_due.size() == 0) begin
                note_failure($sformatf("unexpected result label %0d total %0d range flag %0b",
                    m_component_label, m_component_total, m_out_of_range));
            end else begin
                want = labelings_due.pop_front();
                if (m_component_label !== want.label || m_component_total !== want.total ||
                    m_out_of_range !== want.out_of_range) begin
                    note_failure($sformatf(
                        "result %0d: label %0d/%0d total %0d/%0d range flag %0b/%0b (exp/got)",
                        results_seen, want.label, m_component_label, want.total,
                        m_component_total, want.out_of_range, m_out_of_range));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items taken, %0d results owed",
                cycle_count, items_accepted, items_queued, labelings_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // all items taken, all results back, then let any add walk or clear finish
    task automatic wait_quiet();
        while (items_accepted != items_queued || labelings_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(logic [gcl_pkg::COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_count_reg = value;
        labels_fresh = 1'b0;
        node_count_writes++;
    endtask

    initial begin : stimulus_proc
        int unsigned count_plan [16];
        int unsigned n;
        int unsigned items;
        int unsigned pick;
        count_plan = '{1, 2, 5, 16, 0, 33, 64, 2047, 100, 3, 1024, 12, 1025, 200, 9, 47};

        reset_graph();
        node_count_reg = gcl_pkg::NODE_COUNT_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // full graph after reset: far ends of the node range
        queue_item(gcl_pkg::KIND_ADD, 0, 1023);
        queue_item(gcl_pkg::KIND_QUERY, 1023, 0);
        queue_item(gcl_pkg::KIND_QUERY, 1, 1023);
        queue_item(gcl_pkg::KIND_ADD, 1023, 1022);
        queue_item(gcl_pkg::KIND_QUERY, 1022, 0);
        queue_item(gcl_pkg::KIND_ADD, 1023, 1023);
        queue_item(gcl_pkg::KIND_QUERY, 1000, 0);
        queue_item(KIND_UNUSED, 1023, 1023);
        wait_quiet();

        // eight nodes: merges, ignored edges, range flag, clear
        write_node_count(11'd8);
        queue_item(gcl_pkg::KIND_ADD, 1, 2);
        queue_item(gcl_pkg::KIND_ADD, 3, 2);
        queue_item(gcl_pkg::KIND_QUERY, 3, 0);
        queue_item(gcl_pkg::KIND_ADD, 0, 8);
        queue_item(gcl_pkg::KIND_ADD, 1023, 0);
        queue_item(gcl_pkg::KIND_QUERY, 0, 0);
        queue_item(gcl_pkg::KIND_QUERY, 7, 0);
        queue_item(gcl_pkg::KIND_QUERY, 8, 0);
        queue_item(gcl_pkg::KIND_QUERY, 1023, 1023);
        queue_item(gcl_pkg::KIND_ADD, 5, 5);
        queue_item(gcl_pkg::KIND_CLEAR, 0, 0);
        queue_item(gcl_pkg::KIND_QUERY, 2, 0);
        queue_item(gcl_pkg::KIND_ADD, 7, 6);
        queue_item(gcl_pkg::KIND_QUERY, 6, 0);
        queue_item(gcl_pkg::KIND_QUERY, 7, 0);
        wait_quiet();

        for (int p = 0; p < 16; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 46; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 46; end
                default: begin sender_idle_pct = 19; stall_pct = 19; end
            endcase
            write_node_count(count_plan[p][gcl_pkg::COUNT_W-1:0]);
            n = nodes_in_use(count_plan[p][gcl_pkg::COUNT_W-1:0]);
            // full-size graphs relabel slowly, keep them short
            items = (n >= NODES) ? 40 : 115;
            for (int unsigned i = 0; i < items; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    queue_item(gcl_pkg::KIND_ADD,
                        $urandom_range(0, n - 1), $urandom_range(0, n - 1));
                else if (pick < 85)
                    queue_item(gcl_pkg::KIND_QUERY,
                        $urandom_range(0, n - 1), $urandom_range(0, 1023));
                else if (pick < 88)
                    queue_item(gcl_pkg::KIND_CLEAR,
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
                else if (pick < 93)
                    queue_item(gcl_pkg::KIND_QUERY,
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
                else if (pick < 97)
                    queue_item(gcl_pkg::KIND_ADD,
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    queue_item(KIND_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            wait_quiet();
        end

        $display("%0d items taken, %0d query results checked", items_accepted, results_seen);
        $display("%0d node_count writes from 0 to 2047, with and without stalls on both sides",
            node_count_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d failures in total", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
